/* sv/svmc_pkg.sv */
package svmc_pkg;

    localparam int SUM_W        = 48;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int NORM_OUT_W   = 16;
    localparam int POS_W        = 4;
    localparam int POS_REGS     = 4;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    localparam logic [63:0] SUM_MAX = 64'((64'd1 << SUM_W) - 64'd1);
    localparam logic [NORM_OUT_W-1:0] NORM_OUT_MAX = '1;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_COLLAPSE = 2'd2;

    typedef enum logic [2:0] {
        CFG_NUM_TARGETS = 3'd0,
        CFG_OUTCOME     = 3'd1,
        CFG_POS_0       = 3'd2,
        CFG_POS_1       = 3'd3,
        CFG_POS_2       = 3'd4,
        CFG_POS_3       = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_P1_RD,
        S_P1_DATA,
        S_P1_IM,
        S_P1_ACC,
        S_SQRT,
        S_SQRT_WAIT,
        S_P2_RD,
        S_P2_DATA,
        S_P2_DIVRE,
        S_P2_DIVIM
    } state_t;

endpackage

/* sv/svmc_store.sv */
module svmc_store #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/svmc_sqrt.sv */
module svmc_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [svmc_pkg::SUM_W-1:0]   radicand,
    output logic                         busy,
    output logic                         done,
    output logic [svmc_pkg::ROOT_W-1:0]  root
);
    import svmc_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0] x_reg, x_next;
    logic [SUM_W-1:0] r_reg, r_next;
    logic [SUM_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] trial;

    always_comb
    begin
        trial     = r_reg + b_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next   = radicand;
            r_next   = '0;
            b_next   = SUM_W'(64'd1 << (SUM_W - 2));
            cnt_next = CNT_W'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next    = b_reg >> 2;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            r_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            r_reg    <= r_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

/* sv/svmc_div.sv */
module svmc_div #(
    parameter int DVD_W = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DVD_W-1:0]             dividend,
    input  logic [svmc_pkg::ROOT_W-1:0]  divisor,
    output logic                         done,
    output logic [DVD_W-1:0]             quotient
);
    import svmc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [ROOT_W-1:0] dsr_reg, dsr_next;
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [ROOT_W:0]   trial;
    logic [ROOT_W:0]   diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            q_next   = '0;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next  = dvd_reg << 1;
            rem_next  = ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
            q_next    = {q_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            dvd_reg  <= dvd_next;
            dsr_reg  <= dsr_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* sv/state_vector_measurement_collapse.sv */
// Channel  Direction  Handshake           Payload
// input    in         in_valid/in_stall   command, address, write_real, write_imag
// output   out        out_valid/out_stall read_real, read_imag, norm_out, status
// config   in         APB psel/penable    paddr, pwdata, prdata, pready
//
// A write or an unused command is answered from the idle state; a read first waits in
// the read wait state for the registered store data. A collapse sweeps the store once,
// clearing dropped entries and summing the squared parts of kept ones, takes the square
// root, then divides each kept entry by it in the shared bit-serial divider.
// Reset is asynchronous and active low; the store contents are not cleared.
// No new transfer is taken while a result waits under out_stall.
module state_vector_measurement_collapse #(
    parameter int NUM_QUBITS  = 10,
    parameter int MAX_TARGETS = 4,
    parameter int AMP_WIDTH   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic [NUM_QUBITS-1:0]             address,
    input  logic signed [AMP_WIDTH-1:0]       write_real,
    input  logic signed [AMP_WIDTH-1:0]       write_imag,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [AMP_WIDTH-1:0]       read_real,
    output logic signed [AMP_WIDTH-1:0]       read_imag,
    output logic [svmc_pkg::NORM_OUT_W-1:0]   norm_out,
    output logic                              status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [svmc_pkg::PADDR_W-1:0]      paddr,
    input  logic [svmc_pkg::PDATA_W-1:0]      pwdata,
    output logic [svmc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import svmc_pkg::*;

    localparam int AW     = NUM_QUBITS;
    localparam int W      = AMP_WIDTH;
    localparam int PROD_W = 2 * W;
    localparam int DIVW   = 2 * W - 1;
    localparam logic [2:0] TGT_LIM = 3'((MAX_TARGETS < POS_REGS) ? MAX_TARGETS : POS_REGS);
    localparam logic [DIVW-1:0] QMAX = DIVW'((64'd1 << (W - 1)) - 64'd1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [W-1:0]        amp_re_reg, amp_re_next;
    logic [W-1:0]        amp_im_reg, amp_im_next;
    logic [W-1:0]        res_re_reg, res_re_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        out_re_reg, out_re_next;
    logic [W-1:0]        out_im_reg, out_im_next;
    logic [NORM_OUT_W-1:0] out_norm_reg, out_norm_next;
    logic                out_status_reg, out_status_next;

    logic [2:0]          num_targets_reg;
    logic [3:0]          outcome_reg;
    logic [POS_W-1:0]    pos_reg [POS_REGS];

    logic                in_fire;
    logic                st_wr_en, st_rd_en;
    logic [AW-1:0]       st_wr_addr, st_rd_addr;
    logic [2*W-1:0]      st_wr_data, st_rd_data;
    logic [W-1:0]        rd_re, rd_im;
    logic                sqrt_start, sqrt_busy, sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                div_start, div_done;
    logic [DIVW-1:0]     div_dividend, div_q;
    logic [W-1:0]        mul_op;
    logic signed [PROD_W-1:0] mul_res;
    logic [2:0]          n_act;
    logic                kept;
    logic [15:0]         idx_pad;
    logic                last;
    logic [2:0]          cfg_idx;
    logic                cfg_we;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [PROD_W-1:0] p);
        logic [63:0] sw;
        logic [63:0] pw;
        sw = 64'(s);
        pw = 64'(p);
        if (pw >= SUM_MAX - sw)
            return SUM_W'(SUM_MAX);
        return SUM_W'(sw + pw);
    endfunction

    function automatic logic [DIVW-1:0] magnitude_shifted(input logic [W-1:0] x);
        logic [W-1:0] mag;
        mag = x[W-1] ? W'(-x) : x;
        return {mag, {(W-1){1'b0}}};
    endfunction

    function automatic logic [W-1:0] sat_quot(input logic [DIVW-1:0] q, input logic neg);
        logic [DIVW-1:0] nq;
        nq = -q;
        if (neg)
        begin
            if (q > QMAX + DIVW'(1))
                return {1'b1, {(W-1){1'b0}}};
            return nq[W-1:0];
        end
        if (q > QMAX)
            return QMAX[W-1:0];
        return q[W-1:0];
    endfunction

    svmc_store #(.ADDR_W(AW), .DATA_W(2 * W)) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    svmc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    svmc_div #(.DVD_W(DIVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (root_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_re   = st_rd_data[2*W-1:W];
    assign rd_im   = st_rd_data[W-1:0];
    assign mul_res = $signed(mul_op) * $signed(mul_op);
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign last     = (idx_reg == {AW{1'b1}});
    assign idx_pad  = 16'(idx_reg);
    assign n_act    = (num_targets_reg > TGT_LIM) ? TGT_LIM : num_targets_reg;

    always_comb
    begin
        logic b;
        kept = 1'b1;
        for (int j = 0; j < POS_REGS; j++)
        begin
            b = (32'(pos_reg[j]) < NUM_QUBITS) ? idx_pad[pos_reg[j]] : 1'b0;
            if ((3'(j) < n_act) && (b != outcome_reg[j]))
                kept = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        amp_re_next     = amp_re_reg;
        amp_im_next     = amp_im_reg;
        res_re_next     = res_re_reg;
        root_next       = root_reg;
        out_re_next     = out_re_reg;
        out_im_next     = out_im_reg;
        out_norm_next   = out_norm_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        st_wr_en        = 1'b0;
        st_wr_addr      = idx_reg;
        st_wr_data      = '0;
        st_rd_en        = 1'b0;
        st_rd_addr      = idx_reg;
        sqrt_start      = 1'b0;
        div_start       = 1'b0;
        div_dividend    = magnitude_shifted(rd_re);
        mul_op          = amp_im_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (command)
                        CMD_READ:
                        begin
                            st_rd_en   = 1'b1;
                            st_rd_addr = address;
                            state_next = S_RD_WAIT;
                        end
                        CMD_COLLAPSE:
                        begin
                            sum_next   = '0;
                            idx_next   = '0;
                            state_next = S_P1_RD;
                        end
                        default:
                        begin
                            if (command == CMD_WRITE)
                            begin
                                st_wr_en   = 1'b1;
                                st_wr_addr = address;
                                st_wr_data = {write_real, write_imag};
                            end
                            out_valid_next  = 1'b1;
                            out_re_next     = '0;
                            out_im_next     = '0;
                            out_norm_next   = '0;
                            out_status_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                out_valid_next  = 1'b1;
                out_re_next     = rd_re;
                out_im_next     = rd_im;
                out_norm_next   = '0;
                out_status_next = 1'b0;
                state_next      = S_IDLE;
            end
            S_P1_RD:
            begin
                st_rd_en   = 1'b1;
                state_next = S_P1_DATA;
            end
            S_P1_DATA:
            begin
                amp_re_next = rd_re;
                amp_im_next = rd_im;
                mul_op      = rd_re;
                if (kept)
                begin
                    prod_next  = PROD_W'(mul_res);
                    state_next = S_P1_IM;
                end
                else
                begin
                    st_wr_en   = 1'b1;
                    idx_next   = idx_reg + AW'(1);
                    state_next = last ? S_SQRT : S_P1_RD;
                end
            end
            S_P1_IM:
            begin
                sum_next   = sat_add(sum_reg, prod_reg);
                prod_next  = PROD_W'(mul_res);
                state_next = S_P1_ACC;
            end
            S_P1_ACC:
            begin
                sum_next   = sat_add(sum_reg, prod_reg);
                idx_next   = idx_reg + AW'(1);
                state_next = last ? S_SQRT : S_P1_RD;
            end
            S_SQRT:
            begin
                sqrt_start = 1'b1;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    root_next = sqrt_root;
                    idx_next  = '0;
                    if (sqrt_root == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_re_next     = '0;
                        out_im_next     = '0;
                        out_norm_next   = '0;
                        out_status_next = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_P2_RD;
                    end
                end
            end
            S_P2_RD:
            begin
                if (kept)
                begin
                    st_rd_en   = 1'b1;
                    state_next = S_P2_DATA;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    if (last)
                    begin
                        out_valid_next  = 1'b1;
                        out_re_next     = '0;
                        out_im_next     = '0;
                        out_norm_next   = (root_reg > ROOT_W'(NORM_OUT_MAX)) ?
                                          NORM_OUT_MAX : root_reg[NORM_OUT_W-1:0];
                        out_status_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_P2_DATA:
            begin
                amp_re_next = rd_re;
                amp_im_next = rd_im;
                div_start   = 1'b1;
                state_next  = S_P2_DIVRE;
            end
            S_P2_DIVRE:
            begin
                div_dividend = magnitude_shifted(amp_im_reg);
                if (div_done)
                begin
                    res_re_next = sat_quot(div_q, amp_re_reg[W-1]);
                    div_start   = 1'b1;
                    state_next  = S_P2_DIVIM;
                end
            end
            S_P2_DIVIM:
            begin
                if (div_done)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_data = {res_re_reg, sat_quot(div_q, amp_im_reg[W-1])};
                    idx_next   = idx_reg + AW'(1);
                    if (last)
                    begin
                        out_valid_next  = 1'b1;
                        out_re_next     = '0;
                        out_im_next     = '0;
                        out_norm_next   = (root_reg > ROOT_W'(NORM_OUT_MAX)) ?
                                          NORM_OUT_MAX : root_reg[NORM_OUT_W-1:0];
                        out_status_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_P2_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            sum_reg        <= '0;
            root_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            root_reg       <= root_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        amp_re_reg     <= amp_re_next;
        amp_im_reg     <= amp_im_next;
        res_re_reg     <= res_re_next;
        out_re_reg     <= out_re_next;
        out_im_reg     <= out_im_next;
        out_norm_reg   <= out_norm_next;
        out_status_reg <= out_status_next;
    end

    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_targets_reg <= 3'd1;
            outcome_reg     <= '0;
            pos_reg[0]      <= POS_W'(0);
            pos_reg[1]      <= POS_W'(1);
            pos_reg[2]      <= POS_W'(2);
            pos_reg[3]      <= POS_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_NUM_TARGETS: num_targets_reg <= pwdata[2:0];
                CFG_OUTCOME:     outcome_reg     <= pwdata[3:0];
                CFG_POS_0:       pos_reg[0]      <= pwdata[POS_W-1:0];
                CFG_POS_1:       pos_reg[1]      <= pwdata[POS_W-1:0];
                CFG_POS_2:       pos_reg[2]      <= pwdata[POS_W-1:0];
                CFG_POS_3:       pos_reg[3]      <= pwdata[POS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            CFG_NUM_TARGETS: prdata = PDATA_W'(num_targets_reg);
            CFG_OUTCOME:     prdata = PDATA_W'(outcome_reg);
            CFG_POS_0:       prdata = PDATA_W'(pos_reg[0]);
            CFG_POS_1:       prdata = PDATA_W'(pos_reg[1]);
            CFG_POS_2:       prdata = PDATA_W'(pos_reg[2]);
            CFG_POS_3:       prdata = PDATA_W'(pos_reg[3]);
            default:         prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_real = out_re_reg;
    assign read_imag = out_im_reg;
    assign norm_out  = out_norm_reg;
    assign status    = out_status_reg;

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && command == CMD_READ) |=> (state_reg == S_RD_WAIT))
        else $error("read transfer did not move to the read wait state");

    a_p2_nonzero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P2_RD || state_reg == S_P2_DATA ||
         state_reg == S_P2_DIVRE || state_reg == S_P2_DIVIM) |-> (root_reg != '0))
        else $error("normalising sweep running with a zero norm");

    a_sqrt_owned: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_busy |-> (state_reg == S_SQRT_WAIT))
        else $error("square root unit busy outside its wait state");

endmodule
